// ===== hdl/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg: shared types for the swept circle against segment hit block
// Sequencer states, the queue head status and the fixed result constants.
// ----------------------------------------------------------------------------
package csh_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] NO_HIT_TIME = 17'd65536;
  localparam logic [16:0] TIME_MAX    = 17'h1ffff;
  localparam logic [15:0] NORM_POS    = 16'h7fff;
  localparam logic [15:0] NORM_NEG    = 16'h8000;

  typedef enum logic [5:0] {
    S_IDLE, S_G, S_GG1, S_GG2, S_LEN, S_HX, S_HY, S_EN1, S_EN2, S_DV1, S_DV2,
    S_T, S_C1, S_C2, S_C3, S_A1, S_A2, S_K0, S_QA1, S_QA2, S_QH1, S_QH2,
    S_QC1, S_QC2, S_QC3, S_LIN, S_D1, S_D2, S_SQ, S_T0, S_T1, S_CHK, S_P1,
    S_P2, S_P3, S_L1, S_L2, S_LSQ, S_NX, S_NY, S_NEXT, S_OUT
  } csh_state_e;

  typedef struct packed {
    logic valid;
    logic seg_point;
  } csh_head_t;

endpackage

// ===== hdl/csh_front.sv =====
// ----------------------------------------------------------------------------
// csh_front: query intake and queue
// Accepts queries, flags segments whose ends coincide, and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module csh_front #(
  parameter int W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [W-1:0]     start_x_i,
  input  logic signed [W-1:0]     start_y_i,
  input  logic signed [W-1:0]     move_x_i,
  input  logic signed [W-1:0]     move_y_i,
  input  logic        [W-2:0]     radius_i,
  input  logic signed [W-1:0]     end_a_x_i,
  input  logic signed [W-1:0]     end_a_y_i,
  input  logic signed [W-1:0]     end_b_x_i,
  input  logic signed [W-1:0]     end_b_y_i,
  input  logic                    pop_i,
  output csh_pkg::csh_head_t      head_o,
  output logic        [9*W-2:0]   item_o
);
  import csh_pkg::*;

  localparam int IW = 9 * W - 1;
  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [IW:0]   mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q;
  logic          push;
  logic          pop;
  logic          seg_point;

  assign in_stall_o = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);
  assign seg_point  = (end_a_x_i == end_b_x_i) && (end_a_y_i == end_b_y_i);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= {seg_point, start_x_i, start_y_i, move_x_i, move_y_i, radius_i,
                          end_a_x_i, end_a_y_i, end_b_x_i, end_b_y_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign head_o.valid     = (cnt_q != '0);
  assign head_o.seg_point = mem_q[rd_ptr_q][IW];
  assign item_o           = mem_q[rd_ptr_q][IW-1:0];

endmodule

// ===== hdl/csh_div.sv =====
// ----------------------------------------------------------------------------
// csh_div: fixed point divider
// Restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module csh_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] q_o
);
  localparam int Q  = W + F;
  localparam int CW = $clog2(Q + 1);
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};

  logic [Q-1:0]  num_q, quo_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  d_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, zero_q, busy_q, done_q;
  logic [W:0]    rem_sh, rem_nx;
  logic          ge;
  logic [W-1:0]  ma, mb, v;

  assign ma = a_i[W-1] ? -a_i : a_i;
  assign mb = b_i[W-1] ? -b_i : b_i;

  assign rem_sh = {rem_q[W-1:0], num_q[Q-1]};
  assign ge     = (rem_sh >= {1'b0, d_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {ma, {F{1'b0}}};
      quo_q  <= '0;
      rem_q  <= '0;
      d_q    <= mb;
      neg_q  <= a_i[W-1] ^ b_i[W-1];
      zero_q <= (mb == '0);
    end else if (busy_q) begin
      num_q <= {num_q[Q-2:0], 1'b0};
      quo_q <= {quo_q[Q-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(Q);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_q) v = (quo_q > Q'(LIM_NEG)) ? LIM_NEG : quo_q[W-1:0];
    else       v = (quo_q > Q'(LIM_POS)) ? LIM_POS : quo_q[W-1:0];
  end

  assign q_o    = zero_q ? '0 : (neg_q ? -v : v);
  assign done_o = done_q;

  div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  div_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  div_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");

endmodule

// ===== hdl/csh_sqrt.sv =====
// ----------------------------------------------------------------------------
// csh_sqrt: fixed point square root
// Digit by digit root, one result bit per cycle; zero for inputs at or below 0.
// ----------------------------------------------------------------------------
module csh_sqrt #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] x_i,
  output logic                done_o,
  output logic signed [W-1:0] r_o
);
  localparam int R  = (W + F + 1) / 2;
  localparam int PD = 2 * R - (W - 1 + F);
  localparam int CW = $clog2(R + 1);
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};

  logic [2*R-1:0] opnd_q;
  logic [R+1:0]   rem_q;
  logic [R-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           zero_q, busy_q, done_q;
  logic [R+3:0]   rem_sh, trial, rem_dif;
  logic           ge;

  assign rem_sh  = {rem_q, opnd_q[2*R-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_dif = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= {{PD{1'b0}}, x_i[W-2:0], {F{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
      zero_q <= x_i[W-1] || (x_i == '0);
    end else if (busy_q) begin
      opnd_q <= {opnd_q[2*R-3:0], 2'b00};
      rem_q  <= ge ? rem_dif[R+1:0] : rem_sh[R+1:0];
      root_q <= {root_q[R-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(R);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign r_o = zero_q ? '0 :
               (((R+W)'(root_q) > (R+W)'(LIM_POS)) ? LIM_POS : W'(root_q));
  assign done_o = done_q;

  sqrt_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("square root started while busy");
  sqrt_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("square root done out of turn");
  sqrt_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !r_o[W-1]) else $error("square root result negative");

endmodule

// ===== hdl/csh_back.sv =====
// ----------------------------------------------------------------------------
// csh_back: collision sequencer
// Runs the side test (if any) and both end-cap tests of one query on a shared
// multiplier, divider and square root unit, and holds the result register.
// ----------------------------------------------------------------------------
module csh_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csh_pkg::csh_head_t  head_i,
  input  logic [9*W-2:0]      item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [16:0]         hit_time_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o
);
  import csh_pkg::*;

  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMAX = LIM_POS;
  localparam logic signed [W-1:0] QMIN = LIM_NEG;
  localparam logic signed [W-1:0] QONE = W'(1) << F;
  localparam logic signed [W-1:0] QZERO = '0;
  localparam int NSR = (F >= 15) ? F - 15 : 0;
  localparam int NSL = (F >= 15) ? 0 : 15 - F;
  localparam int TSR = (F >= 16) ? F - 16 : 0;
  localparam int TSL = (F >= 16) ? 0 : 16 - F;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? QMIN : QMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? QMIN : QMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic [2*W-1:0] p;
    logic [W-1:0]   v;
    logic           neg;
    p   = ({{W{1'b0}}, mag(a)} * {{W{1'b0}}, mag(b)}) >> F;
    neg = a[W-1] ^ b[W-1];
    if (neg) v = (p > (2*W)'(LIM_NEG)) ? LIM_NEG : p[W-1:0];
    else     v = (p > (2*W)'(LIM_POS)) ? LIM_POS : p[W-1:0];
    return neg ? -v : v;
  endfunction

  function automatic logic in_unit(input logic signed [W-1:0] t);
    return !t[W-1] && (t <= QONE);
  endfunction

  function automatic logic [15:0] to_norm(input logic signed [W-1:0] x);
    logic [W+8:0] s;
    s = ((W+9)'(mag(x)) >> NSR) << NSL;
    if (x[W-1]) return (s >= (W+9)'(32768)) ? NORM_NEG : (~s[15:0] + 16'd1);
    return (s > (W+9)'(32767)) ? NORM_POS : s[15:0];
  endfunction

  function automatic logic [16:0] to_time(input logic signed [W-1:0] x);
    logic [W+8:0] s;
    s = ((W+9)'(mag(x)) >> TSR) << TSL;
    return (s > (W+9)'(TIME_MAX)) ? TIME_MAX : s[16:0];
  endfunction

  csh_state_e state_q, state_d;
  logic       wait_q, out_valid_q;

  logic signed [W-1:0] sx_q, sy_q, mx_q, my_q, ax_q, ay_q, bx_q, by_q;
  logic        [W-2:0] r_q;
  logic signed [W-1:0] gx_q, gy_q, ex_q, ey_q, acc_q, len_q, hx_q, hy_q;
  logic signed [W-1:0] nx_q, ny_q, en_q, dv_q, t_q, cx_q, cy_q, px_q, py_q;
  logic signed [W-1:0] dx_q, dy_q, qa_q, qh_q, qc_q, sq_q, t0_q;
  logic signed [W-1:0] best_t_q, bnx_q, bny_q;
  logic                hit_q, k_q, flip_q, ok_q;

  logic                out_hit_q;
  logic [16:0]         out_time_q;
  logic [15:0]         out_nx_q, out_ny_q;

  logic signed [W-1:0] mul_a, mul_b, mp, sum_acc, dif_acc, r_ext;
  logic signed [W-1:0] div_a, div_b, div_res, sq_x, sq_res, t_lo, t_hi;
  logic                div_start, sq_start, div_done, sq_done;
  logic                div_state, sq_state, out_load;

  assign r_ext   = {1'b0, r_q};
  assign mp      = qmul(mul_a, mul_b);
  assign sum_acc = qadd(acc_q, mp);
  assign dif_acc = qsub(acc_q, mp);
  assign t_lo    = (t0_q > div_res) ? div_res : t0_q;
  assign t_hi    = (t0_q > div_res) ? t0_q : div_res;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign div_state = (state_q == S_HX) || (state_q == S_HY) || (state_q == S_T) ||
                     (state_q == S_LIN) || (state_q == S_T0) || (state_q == S_T1) ||
                     (state_q == S_NX) || (state_q == S_NY);
  assign sq_state  = (state_q == S_LEN) || (state_q == S_SQ) || (state_q == S_LSQ);

  csh_div #(.W(W), .F(F)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(div_a), .b_i(div_b),
    .done_o(div_done), .q_o(div_res)
  );

  csh_sqrt #(.W(W), .F(F)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(sq_x),
    .done_o(sq_done), .r_o(sq_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (head_i.valid) state_d = head_i.seg_point ? S_K0 : S_G;
      S_G:    state_d = S_GG1;
      S_GG1:  state_d = S_GG2;
      S_GG2:  state_d = S_LEN;
      S_LEN:  if (wait_q && sq_done) state_d = (sq_res == '0) ? S_K0 : S_HX;
      S_HX:   if (wait_q && div_done) state_d = S_HY;
      S_HY:   if (wait_q && div_done) state_d = S_EN1;
      S_EN1:  state_d = S_EN2;
      S_EN2:  state_d = (!flip_q && sum_acc[W-1]) ? S_EN1 : S_DV1;
      S_DV1:  state_d = S_DV2;
      S_DV2:  state_d = (sum_acc == '0) ? S_K0 : S_T;
      S_T:    if (wait_q && div_done) state_d = in_unit(div_res) ? S_C1 : S_K0;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = S_A1;
      S_A1:   state_d = S_A2;
      S_A2:   state_d = S_K0;
      S_K0:   state_d = S_QA1;
      S_QA1:  state_d = S_QA2;
      S_QA2:  state_d = S_QH1;
      S_QH1:  state_d = S_QH2;
      S_QH2:  state_d = S_QC1;
      S_QC1:  state_d = S_QC2;
      S_QC2:  state_d = S_QC3;
      S_QC3: begin
        if (qa_q != '0)      state_d = S_D1;
        else if (qh_q != '0) state_d = S_LIN;
        else                 state_d = S_CHK;
      end
      S_LIN:  if (wait_q && div_done) state_d = S_CHK;
      S_D1:   state_d = S_D2;
      S_D2:   state_d = dif_acc[W-1] ? S_CHK : S_SQ;
      S_SQ:   if (wait_q && sq_done) state_d = S_T0;
      S_T0:   if (wait_q && div_done) state_d = S_T1;
      S_T1:   if (wait_q && div_done) state_d = S_CHK;
      S_CHK:  state_d = (ok_q && (t_q < best_t_q)) ? S_P1 : S_NEXT;
      S_P1:   state_d = S_P2;
      S_P2:   state_d = S_P3;
      S_P3:   state_d = S_L1;
      S_L1:   state_d = S_L2;
      S_L2:   state_d = S_LSQ;
      S_LSQ:  if (wait_q && sq_done) state_d = (sq_res == '0) ? S_NEXT : S_NX;
      S_NX:   if (wait_q && div_done) state_d = S_NY;
      S_NY:   if (wait_q && div_done) state_d = S_NEXT;
      S_NEXT: state_d = k_q ? S_OUT : S_K0;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Unit operands and queue pop.
  always_comb begin
    mul_a = QZERO;
    mul_b = QZERO;
    div_a = QZERO;
    div_b = QZERO;
    unique case (state_q)
      S_GG1: begin mul_a = gx_q; mul_b = gx_q; end
      S_GG2: begin mul_a = gy_q; mul_b = gy_q; end
      S_EN1: begin mul_a = ex_q; mul_b = nx_q; end
      S_EN2: begin mul_a = ey_q; mul_b = ny_q; end
      S_DV1: begin mul_a = mx_q; mul_b = nx_q; end
      S_DV2: begin mul_a = my_q; mul_b = ny_q; end
      S_C1, S_P1: begin mul_a = t_q; mul_b = mx_q; end
      S_C2, S_P2: begin mul_a = t_q; mul_b = my_q; end
      S_A1:  begin mul_a = cx_q; mul_b = hx_q; end
      S_A2:  begin mul_a = cy_q; mul_b = hy_q; end
      S_QA1: begin mul_a = mx_q; mul_b = mx_q; end
      S_QA2: begin mul_a = my_q; mul_b = my_q; end
      S_QH1: begin mul_a = dx_q; mul_b = mx_q; end
      S_QH2: begin mul_a = dy_q; mul_b = my_q; end
      S_QC1: begin mul_a = dx_q; mul_b = dx_q; end
      S_QC2: begin mul_a = dy_q; mul_b = dy_q; end
      S_QC3: begin mul_a = r_ext; mul_b = r_ext; end
      S_D1:  begin mul_a = qh_q; mul_b = qh_q; end
      S_D2:  begin mul_a = qa_q; mul_b = qc_q; end
      S_L1:  begin mul_a = cx_q; mul_b = cx_q; end
      S_L2:  begin mul_a = cy_q; mul_b = cy_q; end
      S_HX:  begin div_a = gx_q; div_b = len_q; end
      S_HY:  begin div_a = gy_q; div_b = len_q; end
      S_T:   begin div_a = qsub(r_ext, en_q); div_b = dv_q; end
      S_LIN: begin div_a = qsub(QZERO, qc_q); div_b = qadd(qh_q, qh_q); end
      S_T0:  begin div_a = qsub(qsub(QZERO, qh_q), sq_q); div_b = qa_q; end
      S_T1:  begin div_a = qadd(qsub(QZERO, qh_q), sq_q); div_b = qa_q; end
      S_NX:  begin div_a = cx_q; div_b = len_q; end
      S_NY:  begin div_a = cy_q; div_b = len_q; end
      default: begin mul_a = QZERO; mul_b = QZERO; end
    endcase
    div_start = div_state && !wait_q;
    sq_start  = sq_state && !wait_q;
    sq_x      = acc_q;
    pop_o     = (state_q == S_IDLE) && head_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start || sq_start)                         wait_q <= 1'b1;
      else if ((div_state && div_done) || (sq_state && sq_done)) wait_q <= 1'b0;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (head_i.valid) begin
        sx_q <= item_i[9*W-2 -: W];
        sy_q <= item_i[8*W-2 -: W];
        mx_q <= item_i[7*W-2 -: W];
        my_q <= item_i[6*W-2 -: W];
        r_q  <= item_i[5*W-2 -: W-1];
        ax_q <= item_i[4*W-1 -: W];
        ay_q <= item_i[3*W-1 -: W];
        bx_q <= item_i[2*W-1 -: W];
        by_q <= item_i[W-1:0];
        best_t_q <= QONE;
        bnx_q  <= QZERO;
        bny_q  <= QZERO;
        hit_q  <= 1'b0;
        k_q    <= 1'b0;
        flip_q <= 1'b0;
      end
      S_G: begin
        gx_q <= qsub(bx_q, ax_q);
        gy_q <= qsub(by_q, ay_q);
        ex_q <= qsub(sx_q, ax_q);
        ey_q <= qsub(sy_q, ay_q);
      end
      S_GG1, S_EN1, S_DV1, S_C1, S_A1, S_QA1, S_QH1, S_QC1, S_D1, S_P1, S_L1:
        acc_q <= mp;
      S_GG2, S_QC2, S_L2: acc_q <= sum_acc;
      S_LEN, S_LSQ: if (wait_q && sq_done) len_q <= sq_res;
      S_HX: if (wait_q && div_done) hx_q <= div_res;
      S_HY: if (wait_q && div_done) begin
        hy_q <= div_res;
        nx_q <= qsub(QZERO, div_res);
        ny_q <= hx_q;
      end
      S_EN2: begin
        en_q <= sum_acc;
        // The normal is turned toward the start centre once, then the dot
        // product is taken again with the turned normal.
        if (!flip_q && sum_acc[W-1]) begin
          flip_q <= 1'b1;
          nx_q   <= qsub(QZERO, nx_q);
          ny_q   <= qsub(QZERO, ny_q);
        end
      end
      S_DV2: dv_q <= sum_acc;
      S_T:   if (wait_q && div_done) t_q <= div_res;
      S_C2: begin
        cx_q  <= qsub(qadd(sx_q, acc_q), ax_q);
        acc_q <= mp;
      end
      S_C3: cy_q <= qsub(qadd(sy_q, acc_q), ay_q);
      S_A2: if (!sum_acc[W-1] && (sum_acc <= len_q) && (t_q < best_t_q)) begin
        best_t_q <= t_q;
        bnx_q    <= nx_q;
        bny_q    <= ny_q;
        hit_q    <= 1'b1;
      end
      S_K0: begin
        px_q <= k_q ? bx_q : ax_q;
        py_q <= k_q ? by_q : ay_q;
        dx_q <= qsub(sx_q, k_q ? bx_q : ax_q);
        dy_q <= qsub(sy_q, k_q ? by_q : ay_q);
      end
      S_QA2: qa_q <= sum_acc;
      S_QH2: qh_q <= sum_acc;
      S_QC3: begin
        qc_q <= dif_acc;
        ok_q <= 1'b0;
      end
      S_LIN: if (wait_q && div_done) begin
        t_q  <= div_res;
        ok_q <= in_unit(div_res);
      end
      S_D2: acc_q <= dif_acc;
      S_SQ: if (wait_q && sq_done) sq_q <= sq_res;
      S_T0: if (wait_q && div_done) t0_q <= div_res;
      S_T1: if (wait_q && div_done) begin
        if (in_unit(t_lo)) begin
          t_q  <= t_lo;
          ok_q <= 1'b1;
        end else if (in_unit(t_hi)) begin
          t_q  <= t_hi;
          ok_q <= 1'b1;
        end
      end
      S_CHK: if (ok_q && (t_q < best_t_q)) begin
        best_t_q <= t_q;
        hit_q    <= 1'b1;
      end
      S_P2: begin
        cx_q  <= qsub(qadd(sx_q, acc_q), px_q);
        acc_q <= mp;
      end
      S_P3: cy_q <= qsub(qadd(sy_q, acc_q), py_q);
      S_NX: if (wait_q && div_done) bnx_q <= div_res;
      S_NY: if (wait_q && div_done) bny_q <= div_res;
      S_NEXT: k_q <= 1'b1;
      S_OUT: if (out_load) begin
        out_hit_q  <= hit_q;
        out_time_q <= hit_q ? to_time(best_t_q) : NO_HIT_TIME;
        out_nx_q   <= hit_q ? to_norm(bnx_q) : 16'd0;
        out_ny_q   <= hit_q ? to_norm(bny_q) : 16'd0;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign hit_time_o  = out_time_q;
  assign normal_x_o  = out_nx_q;
  assign normal_y_o  = out_ny_q;

  pop_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE) && head_i.valid) else $error("queue popped while busy");
  best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !best_t_q[W-1] && (best_t_q <= QONE))
    else $error("best contact time out of range");
  miss_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |-> (out_time_q == NO_HIT_TIME) &&
    (out_nx_q == 16'd0) && (out_ny_q == 16'd0)) else $error("miss with contact data");
  hit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> (out_time_q < NO_HIT_TIME))
    else $error("hit reported at end of step");

endmodule

// ===== hdl/swept_circle_segment_hit.sv =====
// Throughput: one query per back-end run; up to 11 divides and 5 roots, set
// by the single shared divider and square root unit. A 4-entry queue takes
// queries while the back end works. Reset clears the queue and result valid.
// ----------------------------------------------------------------------------
// swept_circle_segment_hit: swept circle against segment contact test
// Earliest contact time (Q1.16) and normal (Q1.15); Q16.16 saturating math.
// ----------------------------------------------------------------------------
module swept_circle_segment_hit #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] move_x_i,
  input  logic signed [COORD_BITS-1:0] move_y_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  input  logic signed [COORD_BITS-1:0] end_a_x_i,
  input  logic signed [COORD_BITS-1:0] end_a_y_i,
  input  logic signed [COORD_BITS-1:0] end_b_x_i,
  input  logic signed [COORD_BITS-1:0] end_b_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [16:0]                  hit_time_o,
  output logic signed [15:0]           normal_x_o,
  output logic signed [15:0]           normal_y_o
);
  import csh_pkg::*;

  csh_head_t                 head;
  logic [9*COORD_BITS-2:0]   item;
  logic                      pop;

  csh_front #(.W(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .start_x_i, .start_y_i, .move_x_i, .move_y_i, .radius_i,
    .end_a_x_i, .end_a_y_i, .end_b_x_i, .end_b_y_i,
    .pop_i(pop), .head_o(head), .item_o(item)
  );

  csh_back #(.W(COORD_BITS), .F(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .head_i(head), .item_i(item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .hit_o, .hit_time_o, .normal_x_o, .normal_y_o
  );

endmodule
